[rtl/lsfc_pkg.sv]
// ============================================================================
// lsfc_pkg
// shared types, widths, reset values and microcode for the state feedback unit
// ============================================================================
package lsfc_pkg;

   localparam int SAMPLE_WIDTH = 18;
   localparam int GAIN_WIDTH   = 20;
   localparam int FORCE_WIDTH  = SAMPLE_WIDTH + 1;

   localparam int ERR_W    = SAMPLE_WIDTH + 1;         // reference or sample differences
   localparam int OPND_W   = GAIN_WIDTH + 1;           // shared multiplier operand
   localparam int PROD_W   = 2 * OPND_W;
   localparam int DERIV_W  = ERR_W + GAIN_WIDTH + 1;   // difference times rate_scale
   localparam int HI_SHIFT = OPND_W - 1;               // split point of a derivative
   localparam int FRAC_SHIFT  = 12;
   localparam int ROUND_SHIFT = 24;
   localparam int ACC_W   = 64;
   localparam int FORCE_W = ACC_W - ROUND_SHIFT;

   localparam int STEP_W      = 4;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((FORCE_WIDTH + 7) / 8) * 8;

   localparam logic [SAMPLE_WIDTH-1:0] ANGLE_TARGET_RST  = '0;
   localparam logic [GAIN_WIDTH-1:0]   POSITION_GAIN_RST = GAIN_WIDTH'(-34130);
   localparam logic [GAIN_WIDTH-1:0]   VELOCITY_GAIN_RST = GAIN_WIDTH'(-37659);
   localparam logic [GAIN_WIDTH-1:0]   ANGLE_GAIN_RST    = GAIN_WIDTH'(-306353);
   localparam logic [GAIN_WIDTH-1:0]   RATE_GAIN_RST     = GAIN_WIDTH'(-54055);
   localparam logic [GAIN_WIDTH-1:0]   RATE_SCALE_RST    = GAIN_WIDTH'(128000);
   localparam logic [SAMPLE_WIDTH-1:0] FORCE_LIMIT_RST   = SAMPLE_WIDTH'(163840);

   typedef enum logic [2:0] {
      REG_ANGLE_TARGET  = 3'd0,
      REG_POSITION_GAIN = 3'd1,
      REG_VELOCITY_GAIN = 3'd2,
      REG_ANGLE_GAIN    = 3'd3,
      REG_RATE_GAIN     = 3'd4,
      REG_RATE_SCALE    = 3'd5,
      REG_FORCE_LIMIT   = 3'd6,
      REG_UNUSED        = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] angle_target;
      logic [GAIN_WIDTH-1:0]   position_gain;
      logic [GAIN_WIDTH-1:0]   velocity_gain;
      logic [GAIN_WIDTH-1:0]   angle_gain;
      logic [GAIN_WIDTH-1:0]   angular_rate_gain;
      logic [GAIN_WIDTH-1:0]   rate_scale;
      logic [SAMPLE_WIDTH-1:0] force_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      A_ERR_POS, A_ERR_ANG, A_DPOS, A_DANG, A_VEL_LO, A_VEL_HI, A_RATE_LO, A_RATE_HI
   } a_sel_type;

   typedef enum logic [2:0] {
      B_POS_GAIN, B_VEL_GAIN, B_ANG_GAIN, B_RATE_GAIN, B_RATE_SCALE
   } b_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE, ACC_LOAD_FRAC, ACC_ADD_FRAC, ACC_SUB, ACC_SUB_HI
   } acc_op_type;

   typedef enum logic [1:0] {
      ST_NONE, ST_VEL, ST_RATE
   } store_type;

   typedef enum logic [1:0] {
      POST_NONE, POST_ROUND, POST_EMIT
   } post_type;

   typedef enum logic [1:0] {
      WAIT_NONE, WAIT_IN, WAIT_OUT
   } wait_type;

   typedef struct packed {
      a_sel_type   a_sel;
      b_sel_type   b_sel;
      acc_op_type  acc_op;
      store_type   store;
      post_type    post;
      wait_type    wait_cond;
      logic        jump;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // control word plus the advance strobe of the step counter
   typedef struct packed {
      ucode_type word;
      logic      go;
   } ctrl_type;

   localparam logic [STEP_W-1:0] STEP_IDLE = '0;

   // product of step n is accumulated or stored in step n+1 (multiplier output is registered)
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{a_sel: A_ERR_POS, b_sel: B_POS_GAIN, acc_op: ACC_NONE, store: ST_NONE,
            post: POST_NONE, wait_cond: WAIT_NONE, jump: 1'b0, target: STEP_IDLE};
      unique case (step)
         4'd0: w.wait_cond = WAIT_IN;
         4'd1: begin
            w.a_sel = A_ERR_POS; w.b_sel = B_POS_GAIN;
         end
         4'd2: begin
            w.a_sel = A_DPOS; w.b_sel = B_RATE_SCALE; w.acc_op = ACC_LOAD_FRAC;
         end
         4'd3: begin
            w.a_sel = A_ERR_ANG; w.b_sel = B_ANG_GAIN; w.store = ST_VEL;
         end
         4'd4: begin
            w.a_sel = A_DANG; w.b_sel = B_RATE_SCALE; w.acc_op = ACC_ADD_FRAC;
         end
         4'd5: begin
            w.a_sel = A_VEL_LO; w.b_sel = B_VEL_GAIN; w.store = ST_RATE;
         end
         4'd6: begin
            w.a_sel = A_VEL_HI; w.b_sel = B_VEL_GAIN; w.acc_op = ACC_SUB;
         end
         4'd7: begin
            w.a_sel = A_RATE_LO; w.b_sel = B_RATE_GAIN; w.acc_op = ACC_SUB_HI;
         end
         4'd8: begin
            w.a_sel = A_RATE_HI; w.b_sel = B_RATE_GAIN; w.acc_op = ACC_SUB;
         end
         4'd9:  w.acc_op = ACC_SUB_HI;
         4'd10: w.post = POST_ROUND;
         4'd11: begin
            w.post = POST_EMIT; w.wait_cond = WAIT_OUT; w.jump = 1'b1;
            w.target = STEP_IDLE;
         end
         default: begin
            w.jump = 1'b1; w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/lqr_state_feedback_controller_unit.sv]
// ============================================================================
// lqr_state_feedback_controller_unit
// full-state feedback force controller for a cart and pendulum
// ============================================================================
// Each input transfer carries a cart position sample, a pendulum angle sample
// and the position setpoint (signed Q6.12). The unit forms the position and
// angle errors, the backward-difference velocities scaled by rate_scale, and
// sums the four gain-weighted terms exactly in a wide accumulator, then rounds
// half up to Q7.12, clamps to +-force_limit and raises saturated on a clamp.
// A microcode sequencer walks a 12-word program, and its eight multiply steps
// share one registered 21x21 signed multiplier (each velocity product against
// its gain is split into a low and a high half). A new item is taken only once
// the program has run through for the previous one, whose result the last step
// moves into an output register when that register is free, so the next item is
// taken while it waits. The user must write gains and limits through the csr
// port only while the unit is idle; the unit itself does not enforce this.
module lqr_state_feedback_controller_unit (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lsfc_pkg::REQ_DATA_W-1:0] req_tdata,   // position_sample[17:0],
                                                        // angle_sample[35:18],
                                                        // position_ref[53:36],
                                                        // zero pad [55:54]
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lsfc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // force_res[18:0], zero pad [23:19]
   output logic                            rsp_tuser,   // saturated
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lsfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lsfc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lsfc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import lsfc_pkg::*;

   cfg_type  cfg;
   ctrl_type ctrl;
   logic     out_free;
   logic signed [SAMPLE_WIDTH-1:0] position_sample, angle_sample, position_ref;
   logic signed [FORCE_WIDTH-1:0]  force_res;
   logic                           saturated;

   // unpack the input transfer
   assign position_sample = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
   assign angle_sample    = $signed(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
   assign position_ref    = $signed(req_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]);

   // register file
   lsfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // microcode step counter, owns the input handshake
   lsfc_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   // arithmetic and output register
   lsfc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .cfg             (cfg),
      .position_sample (position_sample),
      .angle_sample    (angle_sample),
      .position_ref    (position_ref),
      .out_free        (out_free),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .force_res       (force_res),
      .saturated       (saturated)
   );

   // pack the result transfer, pad bits stay zero
   assign rsp_tdata = {{(RSP_DATA_W - FORCE_WIDTH){1'b0}}, force_res};
   assign rsp_tuser = saturated;

endmodule

[rtl/lsfc_csr.sv]
// ============================================================================
// lsfc_csr
// register file behind the apb-style configuration port
// ============================================================================
module lsfc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lsfc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lsfc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lsfc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output lsfc_pkg::cfg_type                cfg
);
   import lsfc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_ANGLE_TARGET:  cfg_in.angle_target      = csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_POSITION_GAIN: cfg_in.position_gain     = csr_pwdata[GAIN_WIDTH-1:0];
            REG_VELOCITY_GAIN: cfg_in.velocity_gain     = csr_pwdata[GAIN_WIDTH-1:0];
            REG_ANGLE_GAIN:    cfg_in.angle_gain        = csr_pwdata[GAIN_WIDTH-1:0];
            REG_RATE_GAIN:     cfg_in.angular_rate_gain = csr_pwdata[GAIN_WIDTH-1:0];
            REG_RATE_SCALE:    cfg_in.rate_scale        = csr_pwdata[GAIN_WIDTH-1:0];
            REG_FORCE_LIMIT:   cfg_in.force_limit       = csr_pwdata[SAMPLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ANGLE_TARGET:  csr_prdata = CSR_DATA_W'(cfg_ff.angle_target);
         REG_POSITION_GAIN: csr_prdata = CSR_DATA_W'(cfg_ff.position_gain);
         REG_VELOCITY_GAIN: csr_prdata = CSR_DATA_W'(cfg_ff.velocity_gain);
         REG_ANGLE_GAIN:    csr_prdata = CSR_DATA_W'(cfg_ff.angle_gain);
         REG_RATE_GAIN:     csr_prdata = CSR_DATA_W'(cfg_ff.angular_rate_gain);
         REG_RATE_SCALE:    csr_prdata = CSR_DATA_W'(cfg_ff.rate_scale);
         REG_FORCE_LIMIT:   csr_prdata = CSR_DATA_W'(cfg_ff.force_limit);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_target      <= ANGLE_TARGET_RST;
         cfg_ff.position_gain     <= POSITION_GAIN_RST;
         cfg_ff.velocity_gain     <= VELOCITY_GAIN_RST;
         cfg_ff.angle_gain        <= ANGLE_GAIN_RST;
         cfg_ff.angular_rate_gain <= RATE_GAIN_RST;
         cfg_ff.rate_scale        <= RATE_SCALE_RST;
         cfg_ff.force_limit       <= FORCE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lsfc_sequencer.sv]
// ============================================================================
// lsfc_sequencer
// step counter over the microcode table, with wait and jump handling
// ============================================================================
module lsfc_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               out_free,
   output logic               req_tready,
   output lsfc_pkg::ctrl_type ctrl
);
   import lsfc_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;
   logic              go;

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.wait_cond)
         WAIT_IN:  go = req_tvalid;
         WAIT_OUT: go = out_free;
         default:  go = 1'b1;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (go) begin
         if (word.jump) begin
            step_in = word.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_tready = (word.wait_cond == WAIT_IN);
   assign ctrl.word  = word;
   assign ctrl.go    = go;

endmodule

[rtl/lsfc_datapath.sv]
// ============================================================================
// lsfc_datapath
// sample differences, shared multiplier, accumulator, rounding and clamp
// ============================================================================
module lsfc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lsfc_pkg::ctrl_type                  ctrl,
   input  lsfc_pkg::cfg_type                   cfg,
   input  logic signed [lsfc_pkg::SAMPLE_WIDTH-1:0] position_sample,
   input  logic signed [lsfc_pkg::SAMPLE_WIDTH-1:0] angle_sample,
   input  logic signed [lsfc_pkg::SAMPLE_WIDTH-1:0] position_ref,
   output logic                                out_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [lsfc_pkg::FORCE_WIDTH-1:0] force_res,
   output logic                                saturated
);
   import lsfc_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] prev_pos_ff, prev_ang_ff;
   logic signed [ERR_W-1:0]        err_pos_ff, err_ang_ff, dpos_ff, dang_ff;
   logic signed [DERIV_W-1:0]      vel_ff, rate_ff;
   logic signed [OPND_W-1:0]       op_a, op_b;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [ACC_W-1:0]        prod_ext, acc_ff, acc_in, rounded;
   logic signed [FORCE_W-1:0]      force_ff, lim_pos, lim_neg;
   logic signed [FORCE_WIDTH-1:0]  force_res_ff, force_res_in;
   logic                           sat_ff, sat_in, valid_ff, valid_in;
   logic                           accept, emit;

   assign accept = ctrl.go && (ctrl.word.wait_cond == WAIT_IN);
   assign emit   = ctrl.go && (ctrl.word.post == POST_EMIT);

   // differences taken once at the input transfer, previous samples move on
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff <= '0;
         prev_ang_ff <= '0;
      end else if (accept) begin
         prev_pos_ff <= position_sample;
         prev_ang_ff <= angle_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_pos_ff <= ERR_W'(position_ref) - ERR_W'(position_sample);
         err_ang_ff <= ERR_W'($signed(cfg.angle_target)) - ERR_W'(angle_sample);
         dpos_ff    <= ERR_W'(position_sample) - ERR_W'(prev_pos_ff);
         dang_ff    <= ERR_W'(angle_sample) - ERR_W'(prev_ang_ff);
      end
   end

   always_comb begin
      unique case (ctrl.word.a_sel)
         A_ERR_POS: op_a = OPND_W'(err_pos_ff);
         A_ERR_ANG: op_a = OPND_W'(err_ang_ff);
         A_DPOS:    op_a = OPND_W'(dpos_ff);
         A_DANG:    op_a = OPND_W'(dang_ff);
         A_VEL_LO:  op_a = $signed({1'b0, vel_ff[HI_SHIFT-1:0]});
         A_VEL_HI:  op_a = OPND_W'($signed(vel_ff[DERIV_W-1:HI_SHIFT]));
         A_RATE_LO: op_a = $signed({1'b0, rate_ff[HI_SHIFT-1:0]});
         A_RATE_HI: op_a = OPND_W'($signed(rate_ff[DERIV_W-1:HI_SHIFT]));
         default:   op_a = '0;
      endcase
   end

   always_comb begin
      unique case (ctrl.word.b_sel)
         B_POS_GAIN:   op_b = OPND_W'($signed(cfg.position_gain));
         B_VEL_GAIN:   op_b = OPND_W'($signed(cfg.velocity_gain));
         B_ANG_GAIN:   op_b = OPND_W'($signed(cfg.angle_gain));
         B_RATE_GAIN:  op_b = OPND_W'($signed(cfg.angular_rate_gain));
         B_RATE_SCALE: op_b = $signed({1'b0, cfg.rate_scale});
         default:      op_b = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.word.store)
         ST_VEL:  vel_ff  <= DERIV_W'(prod_ff);
         ST_RATE: rate_ff <= DERIV_W'(prod_ff);
         default: ;
      endcase
   end

   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      unique case (ctrl.word.acc_op)
         ACC_LOAD_FRAC: acc_in = prod_ext <<< FRAC_SHIFT;
         ACC_ADD_FRAC:  acc_in = acc_ff + (prod_ext <<< FRAC_SHIFT);
         ACC_SUB:       acc_in = acc_ff - prod_ext;
         ACC_SUB_HI:    acc_in = acc_ff - (prod_ext <<< HI_SHIFT);
         default:       acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // round half up to q.12
   assign rounded = acc_ff + (ACC_W'(1) <<< (ROUND_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (ctrl.word.post == POST_ROUND) begin
         force_ff <= rounded[ACC_W-1:ROUND_SHIFT];
      end
   end

   assign lim_pos = $signed(FORCE_W'(cfg.force_limit));
   assign lim_neg = -lim_pos;

   always_comb begin
      priority if (force_ff > lim_pos) begin
         force_res_in = FORCE_WIDTH'(lim_pos);
         sat_in       = 1'b1;
      end else if (force_ff < lim_neg) begin
         force_res_in = FORCE_WIDTH'(lim_neg);
         sat_in       = 1'b1;
      end else begin
         force_res_in = FORCE_WIDTH'(force_ff);
         sat_in       = 1'b0;
      end
   end

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         force_res_ff <= force_res_in;
         sat_ff       <= sat_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign force_res  = force_res_ff;
   assign saturated  = sat_ff;

endmodule

[rtl/lsfc_checker.sv]
// ============================================================================
// lsfc_checker
// port-level checks on the state feedback unit, bound to the top level
// ============================================================================
module lsfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lsfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            csr_pready
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // the unit is busy right after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // a new result never rises out of the step that waits for input
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result without work");

   // no result straight out of reset
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // config port never stalls
   assert property (@(posedge clock) csr_pready)
      else $error("csr_pready low");

endmodule

bind lqr_state_feedback_controller_unit lsfc_checker u_lsfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

[bench/lsfc_force_checker.sv]
// ============================================================================
// lsfc_force_checker
// watches the sample, force and csr ports of the state feedback unit, works
// out the expected force command for every sample transfer and compares it,
// field by field, with the force transfers in order
// ============================================================================
module lsfc_force_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lsfc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [lsfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lsfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lsfc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              fail_count,
   output int                              outstanding,
   output int                              clamp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import lsfc_pkg::*;

   typedef struct packed {
      logic [FORCE_WIDTH-1:0] force_res;
      logic                   saturated;
   } force_cmd_type;

   force_cmd_type           expected_forces[$];
   cfg_type                 gains;
   logic [SAMPLE_WIDTH-1:0] last_position;
   logic [SAMPLE_WIDTH-1:0] last_angle;

   task automatic report_mismatch(input string msg);
      $display("%0t ns force mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // sum of the four weighted errors in Q.36, rounded half up to Q.12, clamped
   function automatic force_cmd_type predict_force(input logic [SAMPLE_WIDTH-1:0] pos_s,
                                                   input logic [SAMPLE_WIDTH-1:0] ang_s,
                                                   input logic [SAMPLE_WIDTH-1:0] set_s);
      longint pos, ang, pos_ref, ang_ref, prev_pos, prev_ang, rscale;
      longint cart_vel, ang_rate, acc, force_q12, lim;
      force_cmd_type cmd;
      pos      = $signed(pos_s);
      ang      = $signed(ang_s);
      pos_ref  = $signed(set_s);
      ang_ref  = $signed(gains.angle_target);
      prev_pos = $signed(last_position);
      prev_ang = $signed(last_angle);
      rscale   = gains.rate_scale;
      cart_vel = (pos - prev_pos) * rscale;
      ang_rate = (ang - prev_ang) * rscale;
      acc  = ((pos_ref - pos) * $signed(gains.position_gain)) <<< FRAC_SHIFT;
      acc += -cart_vel * $signed(gains.velocity_gain);
      acc += ((ang_ref - ang) * $signed(gains.angle_gain)) <<< FRAC_SHIFT;
      acc += -ang_rate * $signed(gains.angular_rate_gain);
      force_q12 = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      lim = gains.force_limit;
      cmd.saturated = 1'b0;
      if (force_q12 > lim) begin
         force_q12     = lim;
         cmd.saturated = 1'b1;
      end else if (force_q12 < -lim) begin
         force_q12     = -lim;
         cmd.saturated = 1'b1;
      end
      cmd.force_res = force_q12[FORCE_WIDTH-1:0];
      return cmd;
   endfunction

   always @(posedge clock) begin
      force_cmd_type want;
      if (reset) begin
         gains = '{angle_target: ANGLE_TARGET_RST, position_gain: POSITION_GAIN_RST,
                   velocity_gain: VELOCITY_GAIN_RST, angle_gain: ANGLE_GAIN_RST,
                   angular_rate_gain: RATE_GAIN_RST, rate_scale: RATE_SCALE_RST,
                   force_limit: FORCE_LIMIT_RST};
         last_position = '0;
         last_angle    = '0;
         expected_forces.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_ANGLE_TARGET:  gains.angle_target      = csr_pwdata[SAMPLE_WIDTH-1:0];
               REG_POSITION_GAIN: gains.position_gain     = csr_pwdata[GAIN_WIDTH-1:0];
               REG_VELOCITY_GAIN: gains.velocity_gain     = csr_pwdata[GAIN_WIDTH-1:0];
               REG_ANGLE_GAIN:    gains.angle_gain        = csr_pwdata[GAIN_WIDTH-1:0];
               REG_RATE_GAIN:     gains.angular_rate_gain = csr_pwdata[GAIN_WIDTH-1:0];
               REG_RATE_SCALE:    gains.rate_scale        = csr_pwdata[GAIN_WIDTH-1:0];
               REG_FORCE_LIMIT:   gains.force_limit       = csr_pwdata[SAMPLE_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_forces.push_back(predict_force(req_tdata[0 +: SAMPLE_WIDTH],
                                                    req_tdata[SAMPLE_WIDTH +: SAMPLE_WIDTH],
                                                    req_tdata[2*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
            last_position = req_tdata[0 +: SAMPLE_WIDTH];
            last_angle    = req_tdata[SAMPLE_WIDTH +: SAMPLE_WIDTH];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_forces.size() == 0) begin
               report_mismatch("force transfer with no sample waiting");
            end else begin
               want = expected_forces.pop_front();
               if (rsp_tdata[FORCE_WIDTH-1:0] !== want.force_res)
                  report_mismatch($sformatf("force_res got %h want %h",
                                            rsp_tdata[FORCE_WIDTH-1:0], want.force_res));
               if (rsp_tuser !== want.saturated)
                  report_mismatch($sformatf("saturated got %b want %b",
                                            rsp_tuser, want.saturated));
               if (want.saturated)
                  clamp_count++;
            end
         end
      end
      outstanding <= expected_forces.size();
   end

endmodule

[bench/tb.sv]
// ============================================================================
// tb
// stimulus and verdict for the lqr state feedback controller unit
// ============================================================================
// Drives sample transfers and csr writes into the unit while a separate
// checker predicts every force command. A directed opening covers extreme
// samples, rounding ties, a zero force limit, the unused register address and
// junk above each register's width; then random segments of mostly smooth
// cart and pendulum trajectories run under four handshake profiles and a
// spread of gain settings, with a long result hold-off to back up the unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsfc_pkg::*;

   localparam int HOLD_CYCLES    = 400;   // long result hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
   localparam int DRAIN_CYCLES   = 30;    // extra settling time after the last force has come back

   localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [GAIN_WIDTH-1:0]   G_MAX = {1'b0, {(GAIN_WIDTH-1){1'b1}}};
   localparam logic [GAIN_WIDTH-1:0]   G_MIN = {1'b1, {(GAIN_WIDTH-1){1'b0}}};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;  // position_sample, angle_sample, position_ref, pad
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // force_res, pad
   logic                  rsp_tuser;         // saturated
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int outstanding;
   int clamp_count;

   // handshake profile and pressure controls
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   // bookkeeping for the summary and the trajectory generator
   int samples_sent = 0;
   int csr_writes   = 0;
   int track_pos    = 0;
   int track_ang    = 0;
   int track_ref    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lqr_state_feedback_controller_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lsfc_force_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .clamp_count (clamp_count)
   );

   // result side: random stalls, plus a long hold-off whenever one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // watchdog: any transfer on any port restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // one sample transfer, after a random number of idle cycles
   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] pos,
                              input logic [SAMPLE_WIDTH-1:0] ang,
                              input logic [SAMPLE_WIDTH-1:0] pos_set);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 3*SAMPLE_WIDTH){1'b0}}, pos_set, ang, pos};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // register write; bits above the register's width carry junk on purpose
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      int          width;
      logic [31:0] keep;
      width = (idx == REG_ANGLE_TARGET || idx == REG_FORCE_LIMIT) ? SAMPLE_WIDTH : GAIN_WIDTH;
      keep  = (32'h1 << width) - 32'h1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= (value & keep) | ($urandom() & ~keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   // stop offering samples and let every pending force come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // mild settings keep the loop near its working point, wild ones span every bit
   task automatic load_gains(input bit mild);
      if (mild) begin
         csr_write(REG_ANGLE_TARGET,  int'($urandom_range(4000)) - 2000);
         csr_write(REG_POSITION_GAIN, int'(POSITION_GAIN_RST) - int'($urandom_range(16000)));
         csr_write(REG_VELOCITY_GAIN, int'(VELOCITY_GAIN_RST) - int'($urandom_range(16000)));
         csr_write(REG_ANGLE_GAIN,    int'($urandom_range(262143)) - 524288);
         csr_write(REG_RATE_GAIN,     int'($urandom_range(131071)) - 131072);
         csr_write(REG_RATE_SCALE,    $urandom_range(200000));
         csr_write(REG_FORCE_LIMIT,   $urandom_range(262143, 65536));
      end else begin
         csr_write(REG_ANGLE_TARGET,  $urandom());
         csr_write(REG_POSITION_GAIN, $urandom());
         csr_write(REG_VELOCITY_GAIN, $urandom());
         csr_write(REG_ANGLE_GAIN,    $urandom());
         csr_write(REG_RATE_GAIN,     $urandom());
         csr_write(REG_RATE_SCALE,    $urandom());
         csr_write(REG_FORCE_LIMIT,   $urandom());
      end
   endtask

   // mostly smooth motion around a setpoint, some raw noise and edge values
   task automatic send_random_sample();
      int mode;
      mode = $urandom_range(99);
      if (mode < 70) begin
         track_pos += int'($urandom_range(600)) - 300;
         track_ang += int'($urandom_range(200)) - 100;
         if ($urandom_range(19) == 0)
            track_ref = int'($urandom_range(40000)) - 20000;
         if (track_pos > 60000 || track_pos < -60000)
            track_pos = track_ref;
         if (track_ang > 8000 || track_ang < -8000)
            track_ang = 0;
         send_sample(SAMPLE_WIDTH'(track_pos), SAMPLE_WIDTH'(track_ang),
                     SAMPLE_WIDTH'(track_ref));
      end else if (mode < 95) begin
         send_sample(SAMPLE_WIDTH'($urandom()), SAMPLE_WIDTH'($urandom()),
                     SAMPLE_WIDTH'($urandom()));
      end else begin
         send_sample($urandom_range(1) ? S_MAX : S_MIN, $urandom_range(1) ? S_MAX : S_MIN,
                     $urandom_range(1) ? S_MAX : S_MIN);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset gains: zero, small and full-scale samples with big jumps
      send_sample('0, '0, '0);
      send_sample(18'd100, 18'd50, 18'd100);
      send_sample(S_MAX, '0, S_MAX);
      send_sample(S_MIN, S_MIN, S_MIN);
      send_sample(S_MAX, S_MAX, S_MIN);
      send_sample(S_MIN, S_MAX, S_MAX);
      send_sample('0, '0, '0);
      send_sample(18'd1, '1, '0);
      wait_idle();

      // position term alone at unit gain, to land on rounding ties
      csr_write(REG_POSITION_GAIN, 32'd1);
      csr_write(REG_VELOCITY_GAIN, 32'd0);
      csr_write(REG_ANGLE_GAIN,    32'd0);
      csr_write(REG_RATE_GAIN,     32'd0);
      csr_write(REG_RATE_SCALE,    32'd0);
      csr_write(REG_FORCE_LIMIT,   32'h3FFFF);
      csr_write(REG_UNUSED,        32'hFFFF_FFFF);  // must be ignored
      send_sample('0, '0, 18'd2048);
      send_sample('0, '0, -18'sd2048);
      send_sample('0, '0, 18'd2047);
      send_sample('0, '0, -18'sd2049);
      send_sample('0, '0, 18'd6144);
      send_sample('0, '0, -18'sd6144);
      wait_idle();

      // zero limit: any nonzero force clamps to zero
      csr_write(REG_FORCE_LIMIT, 32'd0);
      send_sample('0, '0, '0);
      send_sample('0, '0, 18'd4096);
      send_sample('0, '0, -18'sd4096);
      wait_idle();

      // most negative gains, full rate scale and limit
      csr_write(REG_ANGLE_TARGET,  32'(S_MAX));
      csr_write(REG_POSITION_GAIN, 32'(G_MIN));
      csr_write(REG_VELOCITY_GAIN, 32'(G_MIN));
      csr_write(REG_ANGLE_GAIN,    32'(G_MIN));
      csr_write(REG_RATE_GAIN,     32'(G_MIN));
      csr_write(REG_RATE_SCALE,    32'hFFFFF);
      csr_write(REG_FORCE_LIMIT,   32'h3FFFF);
      send_sample(S_MIN, S_MAX, S_MAX);
      send_sample(S_MAX, S_MIN, S_MIN);
      send_sample('0, '0, '0);
      wait_idle();

      // most positive gains
      csr_write(REG_ANGLE_TARGET,  32'(S_MIN));
      csr_write(REG_POSITION_GAIN, 32'(G_MAX));
      csr_write(REG_VELOCITY_GAIN, 32'(G_MAX));
      csr_write(REG_ANGLE_GAIN,    32'(G_MAX));
      csr_write(REG_RATE_GAIN,     32'(G_MAX));
      send_sample(S_MAX, S_MAX, S_MIN);
      send_sample(S_MIN, S_MIN, S_MAX);

      // random segments: four handshake profiles, three gain settings each
      for (int profile = 0; profile < 4; profile++) begin
         case (profile)
            0: begin
               src_idle_pct = 0;
               sink_stall_pct <= 0;
            end
            1: begin
               src_idle_pct = 85;
               sink_stall_pct <= 0;
            end
            2: begin
               src_idle_pct = 0;
               sink_stall_pct <= 85;
            end
            default: begin
               src_idle_pct = 16;
               sink_stall_pct <= 16;
            end
         endcase
         for (int setting = 0; setting < 3; setting++) begin
            wait_idle();
            load_gains(setting != 2);
            // back up the unit while samples keep coming
            if (setting == 0 && (profile == 0 || profile == 2))
               hold_requests <= hold_requests + 1;
            repeat (50) send_random_sample();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d samples and %0d register writes under four handshake profiles",
               samples_sent, csr_writes);
      $display("%0d forces hit the limit, %0d mismatches", clamp_count, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
